### rtl/core/deadline_task_queue_dispatcher_unit_defines.svh
// Assertion macros for the dispatcher.
`ifndef DEADLINE_TASK_QUEUE_DISPATCHER_UNIT_DEFINES_SVH
`define DEADLINE_TASK_QUEUE_DISPATCHER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define DTQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTQ_ASSERT(label, clk, rst, prop, msg)
`define DTQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### rtl/core/dtqd_pkg.sv
`timescale 1ns / 1ps
package dtqd_pkg;
  localparam int TASK_SLOTS_DEF = 16;
  localparam int SERVERS_DEF = 8;

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_TICK     = 3'd1;
  localparam logic [2:0] CMD_LOAD     = 3'd2;
  localparam logic [2:0] CMD_STATE    = 3'd3;
  localparam logic [2:0] CMD_CPU_DONE = 3'd4;
  localparam logic [2:0] CMD_DISPATCH = 3'd5;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_REFUSED  = 3'd2;
  localparam logic [2:0] ST_DISP     = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  localparam logic CFG_SLOTS   = 1'b0;
  localparam logic CFG_SERVERS = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [30:0] task_id;
    logic [30:0] instr_count;
    logic [15:0] time_limit;
    logic [2:0]  server_index;
    logic        cpu_select;
    logic [15:0] cap_primary;
    logic [15:0] cap_secondary;
    logic        server_on;
    logic        high_perf;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] out_task_id;
    logic [30:0] out_instr_count;
    logic [31:0] out_arrival;
    logic [2:0]  out_server;
    logic        out_cpu;
    logic [4:0]  dropped_now;
    logic [4:0]  queued_count;
    logic [31:0] refused_total;
  } rsp_t;

  typedef struct packed {
    logic [30:0] task_id;
    logic [30:0] instr;
    logic [31:0] deadline;
    logic [31:0] arrival;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CHK, S_SWP_RD, S_SWP_CHK,
    S_MIN_RD, S_MIN_CHK, S_FEAS_RD, S_DIV, S_FEAS_CHK, S_RESP
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
  } div_req_t;
endpackage

### rtl/core/dtqd_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module dtqd_div (
  input  logic              clk,
  input  logic              rst,
  input  dtqd_pkg::div_req_t req,
  output logic              done,
  output logic [31:0]       quot
);
  logic [31:0] q;
  logic [16:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;

  assign trial = {rem[15:0], q[31]} - {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        done <= 1'b0;
      end else if (busy) begin
        cnt  <= cnt - 6'd1;
        done <= (cnt == 6'd1);
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.num;
      rem <= '0;
    end else if (busy) begin
      if (!trial[16]) begin
        rem <= trial;
        q   <= {q[30:0], 1'b1};
      end else begin
        rem <= {rem[15:0], q[31]};
        q   <= {q[30:0], 1'b0};
      end
    end
  end

  assign quot = q;
endmodule

### rtl/core/dtqd_slot_mem.sv
`timescale 1ns / 1ps
module dtqd_slot_mem #(
  parameter int TASK_SLOTS = dtqd_pkg::TASK_SLOTS_DEF,
  localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  dtqd_pkg::slot_t     wdata,
  input  logic [AW-1:0]       raddr,
  output dtqd_pkg::slot_t     rdata
);
  dtqd_pkg::slot_t mem [TASK_SLOTS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/deadline_task_queue_dispatcher_unit.sv
`timescale 1ns / 1ps
// Tick, load, state, cpu done and unused codes go straight to the result state; insert
// runs a free-slot search, then a sweep. Dispatch runs one slot scan per walked task
// and two divider capacity checks per server. Throughput: one request at a time; busy
// is high from the cycle after start until the result state and low in the strobe cycle.
// Synchronous active-high reset clears control state, not the slots.
`include "deadline_task_queue_dispatcher_unit_defines.svh"
module deadline_task_queue_dispatcher_unit #(
  parameter int TASK_SLOTS = dtqd_pkg::TASK_SLOTS_DEF,
  parameter int SERVERS = dtqd_pkg::SERVERS_DEF,
  localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
  localparam int SW = (SERVERS > 1) ? $clog2(SERVERS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dtqd_pkg::req_t  req,
  output logic            result_valid,
  output dtqd_pkg::rsp_t  result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data
);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int VW = $clog2(SERVERS + 1);

  dtqd_pkg::state_t state, state_next;
  dtqd_pkg::req_t   r;
  logic [4:0]  slots_in_use;
  logic [3:0]  servers_in_use;
  logic [TASK_SLOTS-1:0] valid, seen;
  logic [15:0] capp [SERVERS];
  logic [15:0] caps [SERVERS];
  logic [SERVERS-1:0] running, pfree, sfree;
  logic [31:0] now, refused;
  logic [CW-1:0] queued;
  logic [4:0]  dropped;
  logic [2:0]  status;
  logic [AW:0] idx;
  logic [AW-1:0] best;
  logic        have_best;
  dtqd_pkg::slot_t bslot, rd;
  logic [VW-1:0] srv;
  logic        which, feasible;
  logic        done_qp;
  logic        qp_ok;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  dtqd_pkg::slot_t mem_wdata;
  dtqd_pkg::div_req_t dreq;
  logic        ddone;
  logic [31:0] dquot;
  logic [32:0] finish;
  logic        in_time;
  logic [AW:0] n_slots;
  logic [VW-1:0] n_srv;
  logic [2:0] o_srv;
  logic        o_cpu;
  dtqd_pkg::slot_t oslot;
  logic        use_p, grant;

  assign n_slots = (32'(slots_in_use) > TASK_SLOTS) ? (AW+1)'(TASK_SLOTS)
                                                    : (AW+1)'(slots_in_use);
  assign n_srv = (32'(servers_in_use) > SERVERS) ? VW'(SERVERS)
                                                 : VW'(servers_in_use);
  assign cfg_ready = 1'b1;
  assign busy = (state != dtqd_pkg::S_IDLE);

  dtqd_slot_mem #(.TASK_SLOTS(TASK_SLOTS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rd)
  );

  dtqd_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dquot));

  logic [15:0] cur_cap;
  assign cur_cap = which ? caps[SW'(srv)] : capp[SW'(srv)];
  assign dreq.start = (state == dtqd_pkg::S_FEAS_RD);
  assign dreq.num = {1'b0, bslot.instr};
  assign dreq.den = cur_cap;
  assign finish = {1'b0, dquot} + {1'b0, now};
  assign in_time = finish < {1'b0, bslot.deadline};
  assign mem_raddr = idx[AW-1:0];

  // which=1: primary result in qp_ok, secondary result in done_qp
  assign use_p = pfree[SW'(srv)] && qp_ok;
  assign grant = which && running[SW'(srv)] &&
                 (use_p || (r.high_perf && sfree[SW'(srv)] && done_qp));

  logic ins_hit;
  assign ins_hit = !valid[idx[AW-1:0]];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dtqd_pkg::S_IDLE:
        if (start) begin
          unique case (req.command)
            dtqd_pkg::CMD_INSERT:   state_next = dtqd_pkg::S_INS_CHK;
            dtqd_pkg::CMD_DISPATCH: state_next = dtqd_pkg::S_MIN_RD;
            default:                state_next = dtqd_pkg::S_RESP;
          endcase
        end
      dtqd_pkg::S_INS_RD: state_next = dtqd_pkg::S_INS_CHK;
      dtqd_pkg::S_INS_CHK:
        if (idx >= n_slots || ins_hit) state_next = dtqd_pkg::S_SWP_RD;
      dtqd_pkg::S_SWP_RD:
        state_next = (idx >= n_slots) ? dtqd_pkg::S_RESP : dtqd_pkg::S_SWP_CHK;
      dtqd_pkg::S_SWP_CHK: state_next = dtqd_pkg::S_SWP_RD;
      dtqd_pkg::S_MIN_RD:
        state_next = (idx >= n_slots) ? (have_best ? dtqd_pkg::S_FEAS_RD
                                                   : dtqd_pkg::S_RESP)
                                      : dtqd_pkg::S_MIN_CHK;
      dtqd_pkg::S_MIN_CHK: state_next = dtqd_pkg::S_MIN_RD;
      dtqd_pkg::S_FEAS_RD:
        state_next = dtqd_pkg::S_DIV;
      dtqd_pkg::S_DIV: if (ddone) state_next = dtqd_pkg::S_FEAS_CHK;
      dtqd_pkg::S_FEAS_CHK:
        if (srv >= n_srv) state_next = dtqd_pkg::S_MIN_RD;
        else if (grant) state_next = dtqd_pkg::S_RESP;
        else state_next = dtqd_pkg::S_FEAS_RD;
      dtqd_pkg::S_RESP: state_next = dtqd_pkg::S_IDLE;
      default: state_next = dtqd_pkg::S_IDLE;
    endcase
    if (state == dtqd_pkg::S_FEAS_RD && srv >= n_srv)
      state_next = dtqd_pkg::S_FEAS_CHK;
  end

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata.task_id = r.task_id;
    mem_wdata.instr = r.instr_count;
    mem_wdata.deadline = now + 32'(r.time_limit);
    mem_wdata.arrival = now;
    unique case (state)
      dtqd_pkg::S_INS_CHK: mem_we = (idx < n_slots) && ins_hit;
      default: mem_we = 1'b0;
    endcase
  end

  function automatic logic [CW-1:0] dec_q(input logic [CW-1:0] q);
    return (q != '0) ? q - CW'(1) : q;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtqd_pkg::S_IDLE;
      slots_in_use <= 5'd16;
      servers_in_use <= 4'd8;
      valid <= '0;
      running <= '0;
      pfree <= '1;
      sfree <= '1;
      now <= '0;
      refused <= '0;
      queued <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < SERVERS; i++) begin
        capp[i] <= 16'd1;
        caps[i] <= 16'd1;
      end
    end else begin
      state <= state_next;
      result_valid <= (state == dtqd_pkg::S_RESP);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dtqd_pkg::CFG_SLOTS:   slots_in_use <= cfg_data[4:0];
          dtqd_pkg::CFG_SERVERS: servers_in_use <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        dtqd_pkg::S_IDLE: if (start) begin
          r <= req;
          idx <= '0;
          dropped <= '0;
          status <= dtqd_pkg::ST_DONE;
          seen <= '0;
          have_best <= 1'b0;
          o_srv <= '0;
          o_cpu <= 1'b0;
          oslot <= '0;
          case (req.command)
            dtqd_pkg::CMD_TICK: now <= now + 32'd1;
            dtqd_pkg::CMD_LOAD: if (32'(req.server_index) < 32'(SERVERS)) begin
              capp[SW'(req.server_index)] <= (req.cap_primary != '0) ? req.cap_primary : 16'd1;
              caps[SW'(req.server_index)] <= (req.cap_secondary != '0) ? req.cap_secondary : 16'd1;
            end
            dtqd_pkg::CMD_STATE: if (32'(req.server_index) < 32'(SERVERS))
              running[SW'(req.server_index)] <= req.server_on;
            dtqd_pkg::CMD_CPU_DONE: if (32'(req.server_index) < 32'(SERVERS)) begin
              if (req.cpu_select) sfree[SW'(req.server_index)] <= 1'b1;
              else pfree[SW'(req.server_index)] <= 1'b1;
            end
            dtqd_pkg::CMD_DISPATCH: status <= dtqd_pkg::ST_NONE;
            default: ;
          endcase
        end
        dtqd_pkg::S_INS_CHK: begin
          if (idx >= n_slots) begin
            status <= dtqd_pkg::ST_REFUSED;
            if (refused != '1) refused <= refused + 32'd1;
            idx <= '0;
          end else if (ins_hit) begin
            status <= dtqd_pkg::ST_INSERTED;
            valid[idx[AW-1:0]] <= 1'b1;
            queued <= queued + CW'(1);
            idx <= '0;
          end else idx <= idx + 1'b1;
        end
        dtqd_pkg::S_SWP_CHK: begin
          if (valid[idx[AW-1:0]] && rd.deadline <= now) begin
            valid[idx[AW-1:0]] <= 1'b0;
            queued <= dec_q(queued);
            if (refused != '1) refused <= refused + 32'd1;
            dropped <= dropped + 5'd1;
          end
          idx <= idx + 1'b1;
        end
        dtqd_pkg::S_MIN_RD: if (idx >= n_slots) begin
          srv <= '0;
          which <= 1'b0;
          feasible <= 1'b0;
          qp_ok <= 1'b0;
        end
        dtqd_pkg::S_MIN_CHK: begin
          if (valid[idx[AW-1:0]] && !seen[idx[AW-1:0]] &&
              (!have_best || rd.deadline < bslot.deadline ||
               (rd.deadline == bslot.deadline && rd.arrival < bslot.arrival))) begin
            have_best <= 1'b1;
            best <= idx[AW-1:0];
            bslot <= rd;
          end
          idx <= idx + 1'b1;
        end
        dtqd_pkg::S_DIV: if (ddone) begin
          done_qp <= in_time;
        end
        dtqd_pkg::S_FEAS_CHK: begin
          if (srv >= n_srv) begin
            // walked every server without a grant; mark seen, drop the task if no server met its deadline
            seen[best] <= 1'b1;
            have_best <= 1'b0;
            idx <= '0;
            if (!feasible) begin
              valid[best] <= 1'b0;
              queued <= dec_q(queued);
              if (refused != '1) refused <= refused + 32'd1;
              dropped <= dropped + 5'd1;
            end
          end else begin
            // which=0: primary result; which=1: secondary result
            if (!which) begin
              qp_ok <= done_qp;
              which <= 1'b1;
            end else begin
              which <= 1'b0;
              srv <= srv + 1'b1;
              if (qp_ok || done_qp) feasible <= 1'b1;
              if (grant) begin
                if (use_p) pfree[SW'(srv)] <= 1'b0;
                else sfree[SW'(srv)] <= 1'b0;
                o_cpu <= !use_p;
                o_srv <= 3'(srv);
                oslot <= bslot;
                valid[best] <= 1'b0;
                queued <= dec_q(queued);
                status <= dtqd_pkg::ST_DISP;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    result.status = status;
    result.out_task_id = oslot.task_id;
    result.out_instr_count = oslot.instr;
    result.out_arrival = oslot.arrival;
    result.out_server = o_srv;
    result.out_cpu = o_cpu;
    result.dropped_now = dropped;
    result.queued_count = 5'(queued);
    result.refused_total = refused;
  end

  `DTQ_ASSERT(a_one_result, clk, rst, result_valid |=> !result_valid, "double result")
  `DTQ_ASSERT(a_idle_after, clk, rst, result_valid |-> !busy, "busy after result")
  `DTQ_ASSERT_RST(a_rst_idle, clk, $past(rst) |-> !busy, "busy after reset")
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int NSLOT = 16;
  localparam int NSRV = 8;
  localparam int STALL_LIMIT = 60000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  dtqd_pkg::req_t req = '0;
  logic result_valid;
  dtqd_pkg::rsp_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = dtqd_pkg::CFG_SLOTS;
  logic [31:0] cfg_data = '0;

  deadline_task_queue_dispatcher_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // shadow copy of the dispatcher
  logic [4:0]  slots_cfg;
  logic [3:0]  servers_cfg;
  bit          slot_busy[NSLOT];
  dtqd_pkg::slot_t slot_mem[NSLOT];
  logic [15:0] cap_p[NSRV];
  logic [15:0] cap_s[NSRV];
  bit          srv_on[NSRV];
  bit          p_free[NSRV];
  bit          s_free[NSRV];
  logic [31:0] now;
  logic [4:0]  queued;
  logic [31:0] refused;

  dtqd_pkg::rsp_t pending_rsp[$];
  int errors = 0;
  int requests = 0;
  int results_seen = 0;
  int dispatched = 0;
  int drops_seen = 0;
  int stall = 0;
  bit quiet = 0;

  function automatic void count_refused();
    if (refused != 32'hFFFF_FFFF) refused++;
  endfunction

  function automatic void drop_task(int s);
    slot_busy[s] = 0;
    if (queued > 0) queued--;
    count_refused();
  endfunction

  function automatic bit meets_deadline(int s, logic [15:0] cap);
    logic [63:0] finish;
    finish = 64'(slot_mem[s].instr / cap) + 64'(now);
    return finish < 64'(slot_mem[s].deadline);
  endfunction

  function automatic dtqd_pkg::rsp_t run_command(dtqd_pkg::req_t r);
    dtqd_pkg::rsp_t o;
    int n, ns, s, best, i, cpu;
    bit seen[NSLOT];
    bit feasible, walking;
    logic [4:0] dropped;
    o = '0;
    dropped = '0;
    n = (slots_cfg > NSLOT) ? NSLOT : slots_cfg;
    ns = (servers_cfg > NSRV) ? NSRV : servers_cfg;
    case (r.command)
      dtqd_pkg::CMD_INSERT: begin
        s = 0;
        while (s < n && slot_busy[s]) s++;
        if (s < n) begin
          slot_busy[s] = 1;
          slot_mem[s].task_id = r.task_id;
          slot_mem[s].instr = r.instr_count;
          slot_mem[s].deadline = now + 32'(r.time_limit);
          slot_mem[s].arrival = now;
          queued++;
          o.status = dtqd_pkg::ST_INSERTED;
        end else begin
          count_refused();
          o.status = dtqd_pkg::ST_REFUSED;
        end
        for (s = 0; s < n; s++)
          if (slot_busy[s] && slot_mem[s].deadline <= now) begin
            drop_task(s);
            dropped++;
          end
      end
      dtqd_pkg::CMD_TICK: now++;
      dtqd_pkg::CMD_LOAD: begin
        cap_p[r.server_index] = (r.cap_primary == 0) ? 16'd1 : r.cap_primary;
        cap_s[r.server_index] = (r.cap_secondary == 0) ? 16'd1 : r.cap_secondary;
      end
      dtqd_pkg::CMD_STATE: srv_on[r.server_index] = r.server_on;
      dtqd_pkg::CMD_CPU_DONE: begin
        if (r.cpu_select) s_free[r.server_index] = 1;
        else p_free[r.server_index] = 1;
      end
      dtqd_pkg::CMD_DISPATCH: begin
        foreach (seen[k]) seen[k] = 0;
        o.status = dtqd_pkg::ST_NONE;
        walking = 1;
        while (walking) begin
          best = -1;
          for (s = 0; s < n; s++) begin
            if (!slot_busy[s] || seen[s]) continue;
            if (best < 0 || slot_mem[s].deadline < slot_mem[best].deadline ||
                (slot_mem[s].deadline == slot_mem[best].deadline &&
                 slot_mem[s].arrival < slot_mem[best].arrival))
              best = s;
          end
          if (best < 0) begin
            walking = 0;
          end else begin
            seen[best] = 1;
            feasible = 0;
            for (i = 0; i < ns && !feasible; i++)
              feasible = meets_deadline(best, cap_p[i]) || meets_deadline(best, cap_s[i]);
            if (!feasible) begin
              drop_task(best);
              dropped++;
            end else begin
              for (i = 0; i < ns && walking; i++) begin
                cpu = -1;
                if (!srv_on[i]) continue;
                if (p_free[i] && meets_deadline(best, cap_p[i])) cpu = 0;
                else if (r.high_perf && s_free[i] && meets_deadline(best, cap_s[i])) cpu = 1;
                if (cpu < 0) continue;
                if (cpu == 0) p_free[i] = 0;
                else s_free[i] = 0;
                o.out_task_id = slot_mem[best].task_id;
                o.out_instr_count = slot_mem[best].instr;
                o.out_arrival = slot_mem[best].arrival;
                o.out_server = 3'(i);
                o.out_cpu = cpu[0];
                slot_busy[best] = 0;
                if (queued > 0) queued--;
                o.status = dtqd_pkg::ST_DISP;
                walking = 0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    o.dropped_now = dropped;
    o.queued_count = queued;
    o.refused_total = refused;
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(field, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) stall <= 0;
      else stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
      if (result_valid) begin
        results_seen++;
        if (pending_rsp.size() == 0) begin
          report("unexpected result", 32'(result.status), 32'hFFFF_FFFF);
        end else begin
          dtqd_pkg::rsp_t w;
          w = pending_rsp.pop_front();
          check_field("status", 32'(result.status), 32'(w.status));
          check_field("task_id", 32'(result.out_task_id), 32'(w.out_task_id));
          check_field("instr", 32'(result.out_instr_count), 32'(w.out_instr_count));
          check_field("arrival", result.out_arrival, w.out_arrival);
          check_field("server", 32'(result.out_server), 32'(w.out_server));
          check_field("cpu", 32'(result.out_cpu), 32'(w.out_cpu));
          check_field("dropped", 32'(result.dropped_now), 32'(w.dropped_now));
          check_field("queued", 32'(result.queued_count), 32'(w.queued_count));
          check_field("refused", result.refused_total, w.refused_total);
          if (w.status == dtqd_pkg::ST_DISP) dispatched++;
          drops_seen += w.dropped_now;
        end
      end
    end
  end

  // caller stays on a clock edge; start is left high for back-to-back requests
  task automatic send(dtqd_pkg::req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(run_command(r));
    requests++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == dtqd_pkg::CFG_SLOTS) slots_cfg = val[4:0];
    else servers_cfg = val[3:0];
  endtask

  function automatic dtqd_pkg::req_t mk(logic [2:0] cmd);
    dtqd_pkg::req_t r;
    r = '0;
    r.command = cmd;
    return r;
  endfunction

  task automatic insert(logic [30:0] id, logic [30:0] instr, logic [15:0] lim);
    dtqd_pkg::req_t r;
    r = mk(dtqd_pkg::CMD_INSERT);
    r.task_id = id;
    r.instr_count = instr;
    r.time_limit = lim;
    send(r);
  endtask

  task automatic server_up(int i, logic [15:0] cp, logic [15:0] cs, bit on);
    dtqd_pkg::req_t r;
    r = mk(dtqd_pkg::CMD_LOAD);
    r.server_index = 3'(i);
    r.cap_primary = cp;
    r.cap_secondary = cs;
    send(r);
    r = mk(dtqd_pkg::CMD_STATE);
    r.server_index = 3'(i);
    r.server_on = on;
    send(r);
  endtask

  task automatic dispatch(bit hp);
    dtqd_pkg::req_t r;
    r = mk(dtqd_pkg::CMD_DISPATCH);
    r.high_perf = hp;
    send(r);
  endtask

  task automatic cpu_done(int i, bit sec);
    dtqd_pkg::req_t r;
    r = mk(dtqd_pkg::CMD_CPU_DONE);
    r.server_index = 3'(i);
    r.cpu_select = sec;
    send(r);
  endtask

  task automatic test_directed();
    dispatch(1'b0);
    send(mk(dtqd_pkg::CMD_TICK));
    server_up(0, 16'd0, 16'hFFFF, 1'b1);
    server_up(7, 16'hFFFF, 16'd0, 1'b1);
    insert(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
    insert(31'd0, 31'd0, 16'd0);
    insert(31'd5, 31'd3, 16'd10);
    insert(31'd6, 31'd3, 16'd10);
    dispatch(1'b0);
    dispatch(1'b0);
    dispatch(1'b1);
    dispatch(1'b1);
    cpu_done(0, 1'b0);
    cpu_done(7, 1'b1);
    server_up(7, 16'd1, 16'd1, 1'b0);
    send(mk(CMD_SPARE6));
    send(mk(CMD_SPARE7));
  endtask

  task automatic test_slot_limits();
    write_reg(dtqd_pkg::CFG_SLOTS, 32'd1);
    insert(31'd11, 31'd1, 16'd50);
    insert(31'd12, 31'd1, 16'd50);
    write_reg(dtqd_pkg::CFG_SERVERS, 32'd0);
    insert(31'd13, 31'd1, 16'd50);
    dispatch(1'b1);
    write_reg(dtqd_pkg::CFG_SLOTS, 32'd16);
    write_reg(dtqd_pkg::CFG_SERVERS, 32'd8);
  endtask

  task automatic random_phase(int count, int slots, int servers);
    dtqd_pkg::req_t r;
    int pick;
    write_reg(dtqd_pkg::CFG_SLOTS, 32'(slots));
    write_reg(dtqd_pkg::CFG_SERVERS, 32'(servers));
    for (int i = 0; i < NSRV; i++)
      server_up(i, 16'($urandom_range(1, 4000)), 16'($urandom), $urandom_range(0, 4) != 0);
    for (int k = 0; k < count; k++) begin
      r = dtqd_pkg::req_t'({$urandom, $urandom, $urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 36) r.command = dtqd_pkg::CMD_INSERT;
      else if (pick < 50) r.command = dtqd_pkg::CMD_TICK;
      else if (pick < 56) r.command = dtqd_pkg::CMD_LOAD;
      else if (pick < 62) r.command = dtqd_pkg::CMD_STATE;
      else if (pick < 78) r.command = dtqd_pkg::CMD_CPU_DONE;
      else if (pick < 98) r.command = dtqd_pkg::CMD_DISPATCH;
      else r.command = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
      if ($urandom_range(0, 3) != 0) r.instr_count = 31'($urandom_range(0, 60000));
      if ($urandom_range(0, 3) != 0) r.time_limit = 16'($urandom_range(0, 40));
      if ($urandom_range(0, 2) != 0) r.cap_primary = 16'($urandom_range(0, 5000));
      if ($urandom_range(0, 2) == 0) r.server_on = 1'b1;
      send(r);
      if (k == count / 2 && slots == 16) drain();
    end
  endtask

  initial begin
    slots_cfg = 5'd16;
    servers_cfg = 4'd8;
    foreach (slot_busy[i]) begin
      slot_busy[i] = 0;
      slot_mem[i] = '0;
    end
    foreach (cap_p[i]) begin
      cap_p[i] = 16'd1;
      cap_s[i] = 16'd1;
      srv_on[i] = 0;
      p_free[i] = 1;
      s_free[i] = 1;
    end
    now = '0;
    queued = '0;
    refused = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_slot_limits();
    random_phase(250, 16, 8);
    random_phase(300, 1, 1);
    random_phase(300, 5, 0);
    random_phase(300, 16, 3);
    quiet = 1;
    random_phase(300, 9, 8);
    drain();
    repeat (40) @(posedge clk);
    $display("requests %0d, results %0d, dispatched %0d, tasks dropped %0d",
             requests, results_seen, dispatched, drops_seen);
    $display("covered slot counts 1, 5, 9 and 16, server counts 0, 1, 3 and 8, all commands");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/dtqd_pkg.sv
rtl/core/dtqd_div.sv
rtl/core/dtqd_slot_mem.sv
rtl/core/deadline_task_queue_dispatcher_unit.sv
tb/tb.sv
